### hdl/wsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wsu_pkg;

    localparam int LEN_W = 64;

    // header field values
    localparam logic [6:0] CODE_CLOSE = 7'h08;
    localparam logic [6:0] LEN_EXT16  = 7'd126;
    localparam logic [6:0] LEN_EXT64  = 7'd127;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [1:0] KEY_LAST    = 2'd3;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [2:0] {
        PH_HEAD   = 3'd0,
        PH_LEN    = 3'd1,
        PH_EXT    = 3'd2,
        PH_KEY    = 3'd3,
        PH_DATA   = 3'd4,
        PH_CLOSED = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_EMPTY = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_byte;
        logic [6:0] frame_code;
        logic       frame_last;
    } t_result;

    // queue to output stage handshake
    typedef struct packed {
        logic not_empty;
        logic pop;
    } t_queue_ctl;

endpackage

`default_nettype wire

### hdl/websocket_frame_unmasker.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Valid        Stall        Beat fields
// --------  ---  -----------  -----------  ---------------------------------------------
// in        in   i_in_valid   o_in_stall   i_stream_byte
// out       out  o_out_valid  i_out_stall  o_kind, o_data_byte, o_frame_code, o_frame_last
//
// One input beat per cycle while o_in_stall is low; the parser state is registered.
// A result goes from the parser through the result queue and the output register
// to the output (parser -> result queue -> output register).
// o_in_stall rises only when the result queue holds QUEUE_DEPTH beats.
// Synchronous active-low reset returns the parser to the first header byte
// and empties the queue and the output register; a close frame is sticky until reset.
module websocket_frame_unmasker import wsu_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_stream_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_data_byte,
    output logic [6:0]      o_frame_code,
    output logic            o_frame_last
);

    logic       w_push;
    logic       w_full;
    t_result    w_front_result;
    t_result    w_head;
    t_result    w_out;
    t_queue_ctl w_qctl;
    logic       w_not_empty;

    // front: header parsing, length assembly, key capture, unmasking
    wsu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_stream_byte(i_stream_byte),
        .i_queue_full (w_full),
        .o_in_stall   (o_in_stall),
        .o_push       (w_push),
        .o_result     (w_front_result)
    );

    // decoupling queue so each side can stall on its own
    wsu_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_result    (w_front_result),
        .i_pop       (w_qctl.pop),
        .o_full      (w_full),
        .o_not_empty (w_not_empty),
        .o_head      (w_head)
    );

    // back: output register toward the consumer
    wsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_not_empty (w_not_empty),
        .i_head      (w_head),
        .o_ctl       (w_qctl),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (w_out)
    );

    assign o_kind       = w_out.kind;
    assign o_data_byte  = w_out.data_byte;
    assign o_frame_code = w_out.frame_code;
    assign o_frame_last = w_out.frame_last;

endmodule

`default_nettype wire

### hdl/wsu_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Header parser and unmasker. One byte per cycle while the queue is not full; results go to the queue.
module wsu_front import wsu_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [7:0] i_stream_byte,
    input  wire logic       i_queue_full,
    output logic            o_in_stall,
    output logic            o_push,
    output t_result         o_result
);

    t_phase             r_phase,    n_phase;
    logic [6:0]         r_code,     n_code;
    logic [LEN_W-1:0]   r_rem,      n_rem;
    logic [3:0]         r_ext_left, n_ext_left;
    logic [31:0]        r_mask_key, n_mask_key;
    logic [1:0]         r_key_pos,  n_key_pos;

    logic               w_accept;
    logic [3:0]         w_ext_dec;
    logic [7:0]         w_key_byte;
    logic               w_data_last;

    assign w_accept    = i_in_valid & ~i_queue_full;
    assign o_in_stall  = i_queue_full;
    assign w_ext_dec   = r_ext_left - 4'd1;
    // key byte 0 sits in the top byte of the key register
    assign w_key_byte  = r_mask_key[{~r_key_pos, 3'b000} +: 8];
    assign w_data_last = (r_rem == LEN_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEAD;
            r_ext_left <= '0;
            r_key_pos  <= '0;
        end else begin
            r_phase    <= n_phase;
            r_ext_left <= n_ext_left;
            r_key_pos  <= n_key_pos;
        end
    end

    // payload registers, always set before use
    always_ff @(posedge i_clk) begin
        r_code     <= n_code;
        r_rem      <= n_rem;
        r_mask_key <= n_mask_key;
    end

    always_comb begin
        n_phase    = r_phase;
        n_code     = r_code;
        n_rem      = r_rem;
        n_ext_left = r_ext_left;
        n_mask_key = r_mask_key;
        n_key_pos  = r_key_pos;
        o_push     = 1'b0;
        o_result   = '{kind: KIND_DATA, data_byte: 8'd0, frame_code: r_code, frame_last: 1'b0};

        if (w_accept) begin
            case (r_phase)
                PH_CLOSED: begin
                    // swallow everything until reset
                end
                PH_LEN: begin
                    n_key_pos  = '0;
                    n_mask_key = '0;
                    if (i_stream_byte[6:0] == LEN_EXT16) begin
                        n_rem      = '0;
                        n_ext_left = EXT16_BYTES;
                        n_phase    = PH_EXT;
                    end else if (i_stream_byte[6:0] == LEN_EXT64) begin
                        n_rem      = '0;
                        n_ext_left = EXT64_BYTES;
                        n_phase    = PH_EXT;
                    end else begin
                        n_rem      = LEN_W'(i_stream_byte[6:0]);
                        n_ext_left = '0;
                        n_phase    = PH_KEY;
                    end
                end
                PH_EXT: begin
                    n_rem      = {r_rem[LEN_W-9:0], i_stream_byte};
                    n_ext_left = w_ext_dec;
                    if (w_ext_dec == 4'd0) begin
                        n_phase = PH_KEY;
                    end
                end
                PH_KEY: begin
                    n_mask_key = {r_mask_key[23:0], i_stream_byte};
                    if (r_key_pos == KEY_LAST) begin
                        n_key_pos = '0;
                        if (r_rem == '0) begin
                            n_phase  = PH_HEAD;
                            o_push   = 1'b1;
                            o_result = '{kind: KIND_EMPTY, data_byte: 8'd0,
                                         frame_code: r_code, frame_last: 1'b1};
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end else begin
                        n_key_pos = r_key_pos + 2'd1;
                    end
                end
                PH_DATA: begin
                    n_key_pos = r_key_pos + 2'd1;
                    n_rem     = r_rem - LEN_W'(1);
                    if (w_data_last) begin
                        n_phase   = PH_HEAD;
                        n_key_pos = '0;
                    end
                    o_push   = 1'b1;
                    o_result = '{kind: KIND_DATA, data_byte: i_stream_byte ^ w_key_byte,
                                 frame_code: r_code, frame_last: w_data_last};
                end
                default: begin
                    // header byte; unused phase codes land here too
                    n_code = i_stream_byte[6:0];
                    if (i_stream_byte[6:0] == CODE_CLOSE) begin
                        n_phase  = PH_CLOSED;
                        o_push   = 1'b1;
                        o_result = '{kind: KIND_CLOSE, data_byte: 8'd0,
                                     frame_code: CODE_CLOSE, frame_last: 1'b1};
                    end else begin
                        n_phase = PH_LEN;
                    end
                end
            endcase
        end
    end

    a_push_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> w_accept)
        else $error("result pushed without an accepted byte");

    a_closed_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CLOSED) |=> (r_phase == PH_CLOSED))
        else $error("left closed state without reset");

    a_no_push_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CLOSED) |-> !o_push)
        else $error("result after close");

endmodule

`default_nettype wire

### hdl/wsu_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Small result FIFO between parser and output stage.
module wsu_queue import wsu_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  t_result     i_result,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_not_empty,
    output t_result     o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_result            r_mem [DEPTH];
    t_result            r_head;
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_head      = r_head;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // head register tracks the next read slot; a push into that slot bypasses
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_result;
        end
        if (i_push && (r_wr_ptr == n_rd_ptr)) begin
            r_head <= i_result;
        end else begin
            r_head <= r_mem[n_rd_ptr];
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> !o_full)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_not_empty)
        else $error("queue underflow");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("queue count lost a push");

endmodule

`default_nettype wire

### hdl/wsu_back.sv
`timescale 1ns / 1ps
`default_nettype none

// Output register: takes the queue head whenever the queue is not empty and the register is empty or being drained.
module wsu_back import wsu_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_not_empty,
    input  t_result     i_head,
    output t_queue_ctl  o_ctl,
    output logic        o_out_valid,
    input  wire logic   i_out_stall,
    output t_result     o_result
);

    logic       r_valid, n_valid;
    t_result    r_result;
    logic       w_load;

    assign w_load          = i_not_empty && (!r_valid || !i_out_stall);
    assign o_ctl.not_empty = i_not_empty;
    assign o_ctl.pop       = w_load;
    assign o_out_valid     = r_valid;
    assign o_result        = r_result;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_result <= i_head;
        end
    end

    a_pop_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.pop |-> o_ctl.not_empty)
        else $error("output stage popped an empty queue");

endmodule

`default_nettype wire
